/* sv/knn_pkg.sv */
`timescale 1ns / 1ps

package knn_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 16;

	// Fixed widths of the item fields.
	localparam int K_BITS    = 7;
	localparam int FUNC_BITS = 2;
	localparam logic [K_BITS-1:0] K_RESET = 7'd3;

	// Function codes carried on the input side.
	localparam logic [FUNC_BITS-1:0] FUNC_LOAD     = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_CLASSIFY = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_CLEAR    = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_D_ADDR,
		ST_D_X,
		ST_D_Y,
		ST_D_WR,
		ST_S_START,
		ST_S_SCAN,
		ST_S_VOTE,
		ST_DONE
	} state_t;

	// Control of the shared squared-distance unit.
	typedef struct packed {
		logic sel_y;
		logic latch;
	} dctl_t;

endpackage

/* sv/knn_ram.sv */
`timescale 1ns / 1ps

module knn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* sv/knn_sqdist.sv */
`timescale 1ns / 1ps

// Shared squaring unit: one signed multiplier, used once for x and once for y.
module knn_sqdist #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  knn_pkg::dctl_t          ctl,
	input  logic [COORD_BITS-1:0]   ref_x,
	input  logic [COORD_BITS-1:0]   ref_y,
	input  logic [COORD_BITS-1:0]   qry_x,
	input  logic [COORD_BITS-1:0]   qry_y,
	output logic [2*COORD_BITS+1:0] sq_sum
);

	logic signed [COORD_BITS:0]     diff;
	logic signed [2*COORD_BITS+1:0] sq;
	logic [2*COORD_BITS:0]          prod_q;
	logic [2*COORD_BITS:0]          acc_q;

	always_comb begin
		if (ctl.sel_y) begin
			diff = $signed({ref_y[COORD_BITS-1], ref_y}) - $signed({qry_y[COORD_BITS-1], qry_y});
		end else begin
			diff = $signed({ref_x[COORD_BITS-1], ref_x}) - $signed({qry_x[COORD_BITS-1], qry_x});
		end
		sq = diff * diff;
	end

	always_ff @(posedge clk) begin
		prod_q <= sq[2*COORD_BITS:0];
		if (ctl.latch) begin
			acc_q <= prod_q;
		end
	end

	assign sq_sum = {1'b0, acc_q} + {1'b0, prod_q};

endmodule

/* sv/knn_binary_classifier.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Contents (lowest bits first)
// s_*       in         s_tvalid / s_tready  tuser func, tdata coord_x, coord_y, label
// m_*       out        m_tvalid / m_tready  tdata class_label, tie_unresolved, voters_used
// cfg_*     in         cfg_we               cfg_wdata k_neighbors
//
// A load, a clear or an unused function code is taken in the idle state and leaves the input open.
// A classify closes the input once its item is accepted, until its result is moved to
// the output register, which waits while an earlier result is held for the receiver:
// one squaring multiplier computes every distance, x squared then y squared per point,
// then one scan of the distance memory per voter picks the next nearest point.
// Reset clears the point count, the control state and the output valid, and sets K to three.
// The block takes no item while a classify runs; a result waits in the output register.

module knn_binary_classifier #(
	parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = knn_pkg::COORD_BITS_DEF,
	localparam int CW    = $clog2(MAX_POINTS + 1),
	localparam int IN_W  = ((2 * COORD_BITS + 1 + 7) / 8) * 8,
	localparam int OUT_W = ((2 + CW + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [knn_pkg::K_BITS-1:0]   cfg_wdata,  // k_neighbors
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [IN_W-1:0]              s_tdata,    // coord_x, coord_y, label, zero fill
	input  logic [knn_pkg::FUNC_BITS-1:0] s_tuser,   // func
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [OUT_W-1:0]             m_tdata     // class_label, tie_unresolved, voters_used
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int DW = 2 * COORD_BITS + 2;
	localparam int PW = 2 * COORD_BITS + 1;
	localparam int MW = (knn_pkg::K_BITS > CW) ? knn_pkg::K_BITS : CW;

	knn_pkg::state_t state_q, state_d;

	logic [knn_pkg::K_BITS-1:0] k_q;
	logic [CW-1:0]              count_q;
	logic [COORD_BITS-1:0]      qx_q, qy_q;
	logic [CW-1:0]              idx_q, kc_q, used_q, v0_q, v1_q;
	logic [DW-1:0]              best_d_q, last_d_q;
	logic [CW-1:0]              best_i_q, last_i_q;
	logic                       best_lbl_q, best_v_q, have_last_q;
	logic                       out_valid_q, out_cls_q, out_tie_q;
	logic [CW-1:0]              out_used_q;

	// Input item fields.
	logic [COORD_BITS-1:0] in_x, in_y;
	logic                  in_label, in_acc;
	assign in_x     = s_tdata[COORD_BITS-1:0];
	assign in_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign in_label = s_tdata[2*COORD_BITS];
	assign in_acc   = s_tvalid && s_tready;

	// Memory ports.
	logic          pt_we;
	logic [AW-1:0] pt_waddr, pt_raddr;
	logic [PW-1:0] pt_wdata, pt_rdata;
	logic          dist_we;
	logic [AW-1:0] dist_raddr;
	logic [DW:0]   dist_rdata;
	logic [DW-1:0] dist_new;
	knn_pkg::dctl_t dctl;

	knn_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pt_ram (
		.clk  (clk),
		.we   (pt_we),
		.waddr(pt_waddr),
		.wdata(pt_wdata),
		.raddr(pt_raddr),
		.rdata(pt_rdata)
	);

	knn_sqdist #(.COORD_BITS(COORD_BITS)) u_sqdist (
		.clk   (clk),
		.ctl   (dctl),
		.ref_x (pt_rdata[COORD_BITS-1:0]),
		.ref_y (pt_rdata[2*COORD_BITS-1:COORD_BITS]),
		.qry_x (qx_q),
		.qry_y (qy_q),
		.sq_sum(dist_new)
	);

	knn_ram #(.WIDTH(DW + 1), .DEPTH(MAX_POINTS)) u_dist_ram (
		.clk  (clk),
		.we   (dist_we),
		.waddr(idx_q[AW-1:0]),
		.wdata({pt_rdata[2*COORD_BITS], dist_new}),
		.raddr(dist_raddr),
		.rdata(dist_rdata)
	);

	// Scan comparison: a candidate must rank after the last chosen point, and
	// it replaces the running best only when strictly nearer, so that equal
	// distances keep load order.
	logic [DW-1:0] cand_d;
	logic          cand_lbl, cand_elig, cand_better;
	logic [CW-1:0] idx_inc, used_inc, v0_inc, v1_inc;
	logic          last_point, more_votes;
	logic [MW-1:0] k_ext, cnt_ext;

	always_comb begin
		cand_d      = dist_rdata[DW-1:0];
		cand_lbl    = dist_rdata[DW];
		cand_elig   = !have_last_q || (cand_d > last_d_q) ||
		              ((cand_d == last_d_q) && (idx_q > last_i_q));
		cand_better = !best_v_q || (cand_d < best_d_q);
		idx_inc     = idx_q + 1'b1;
		last_point  = (idx_inc == count_q);
		used_inc    = used_q + 1'b1;
		v0_inc      = v0_q + {{(CW-1){1'b0}}, !best_lbl_q};
		v1_inc      = v1_q + {{(CW-1){1'b0}}, best_lbl_q};
		more_votes  = (used_inc < kc_q) || ((v0_inc == v1_inc) && (used_inc < count_q));
		k_ext       = MW'(k_q);
		cnt_ext     = MW'(count_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			knn_pkg::ST_IDLE: begin
				if (in_acc && s_tuser == knn_pkg::FUNC_CLASSIFY) begin
					state_d = (count_q == '0) ? knn_pkg::ST_DONE : knn_pkg::ST_D_ADDR;
				end
			end
			knn_pkg::ST_D_ADDR:  state_d = knn_pkg::ST_D_X;
			knn_pkg::ST_D_X:     state_d = knn_pkg::ST_D_Y;
			knn_pkg::ST_D_Y:     state_d = knn_pkg::ST_D_WR;
			knn_pkg::ST_D_WR: begin
				state_d = last_point ? knn_pkg::ST_S_START : knn_pkg::ST_D_ADDR;
			end
			knn_pkg::ST_S_START: state_d = knn_pkg::ST_S_SCAN;
			knn_pkg::ST_S_SCAN: begin
				if (last_point) begin
					state_d = knn_pkg::ST_S_VOTE;
				end
			end
			knn_pkg::ST_S_VOTE: begin
				state_d = more_votes ? knn_pkg::ST_S_START : knn_pkg::ST_DONE;
			end
			knn_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = knn_pkg::ST_IDLE;
				end
			end
			default: state_d = knn_pkg::ST_IDLE;
		endcase
	end

	// Memory and multiplier controls.
	always_comb begin
		pt_we      = 1'b0;
		pt_waddr   = count_q[AW-1:0];
		pt_wdata   = {in_label, in_y, in_x};
		pt_raddr   = idx_q[AW-1:0];
		dist_we    = 1'b0;
		dist_raddr = idx_inc[AW-1:0];
		dctl       = '0;
		unique case (state_q)
			knn_pkg::ST_IDLE: begin
				pt_we = in_acc && (s_tuser == knn_pkg::FUNC_LOAD) &&
				        (count_q < CW'(MAX_POINTS));
			end
			knn_pkg::ST_D_Y: begin
				dctl.sel_y = 1'b1;
				dctl.latch = 1'b1;
			end
			knn_pkg::ST_D_WR:    dist_we    = 1'b1;
			knn_pkg::ST_S_START: dist_raddr = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= knn_pkg::ST_IDLE;
			k_q         <= knn_pkg::K_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				k_q <= cfg_wdata;
			end
			if (pt_we) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == knn_pkg::ST_IDLE && in_acc &&
			             s_tuser == knn_pkg::FUNC_CLEAR) begin
				count_q <= '0;
			end
			if (state_q == knn_pkg::ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			knn_pkg::ST_IDLE: begin
				qx_q        <= in_x;
				qy_q        <= in_y;
				idx_q       <= '0;
				used_q      <= '0;
				v0_q        <= '0;
				v1_q        <= '0;
				have_last_q <= 1'b0;
				kc_q        <= (k_ext > cnt_ext) ? count_q : CW'(k_ext);
			end
			knn_pkg::ST_D_WR: idx_q <= idx_inc;
			knn_pkg::ST_S_START: begin
				idx_q    <= '0;
				best_v_q <= 1'b0;
			end
			knn_pkg::ST_S_SCAN: begin
				if (cand_elig && cand_better) begin
					best_v_q   <= 1'b1;
					best_d_q   <= cand_d;
					best_i_q   <= idx_q;
					best_lbl_q <= cand_lbl;
				end
				idx_q <= idx_inc;
			end
			knn_pkg::ST_S_VOTE: begin
				last_d_q    <= best_d_q;
				last_i_q    <= best_i_q;
				have_last_q <= 1'b1;
				used_q      <= used_inc;
				v0_q        <= v0_inc;
				v1_q        <= v1_inc;
			end
			knn_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_tie_q  <= (v0_q == v1_q);
					out_cls_q  <= !(v0_q > v1_q);
					out_used_q <= used_q;
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == knn_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_used_q, out_tie_q, out_cls_q});

endmodule

/* sv/knn_checker.sv */
`timescale 1ns / 1ps

module knn_checker #(
	parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF,
	localparam int CW    = $clog2(MAX_POINTS + 1),
	localparam int OUT_W = ((2 + CW + 7) / 8) * 8
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [knn_pkg::FUNC_BITS-1:0] s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [OUT_W-1:0]              m_tdata
);

	// A classify keeps the input side closed on the following cycle.
	a_classify_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == knn_pkg::FUNC_CLASSIFY |=> !s_tready)
		else $error("input still open after a classify item");

	// After a load, a clear or an unused code the input side stays open on the following cycle.
	a_short_ops: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != knn_pkg::FUNC_CLASSIFY |=> s_tready)
		else $error("input closed after a one-cycle item");

	// An unresolved tie always reports class one.
	a_tie_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[0])
		else $error("unresolved tie with class zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind knn_binary_classifier knn_checker #(.MAX_POINTS(MAX_POINTS)) u_knn_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
